// ===== design/temp_humidity_compensation_assert.svh =====
// Assertion macros shared by the temperature and humidity compensation block.
`ifndef TEMP_HUMIDITY_COMPENSATION_ASSERT_SVH
`define TEMP_HUMIDITY_COMPENSATION_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define THC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define THC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/thc_pkg.sv =====
// Shared types, constants and the divide-by-100 helper of the compensation block.
`timescale 1ns / 1ps
`default_nettype none

package thc_pkg;

  // Field widths.
  localparam int TEMP_RAW_W = 20;
  localparam int HUM_RAW_W  = 16;
  localparam int TEMP_W     = 17;  // unsaturated temperature, two's complement
  localparam int TEMP_OUT_W = 16;
  localparam int HUM_OUT_W  = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Register indexes of the configuration channel.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_T1, REG_T2, REG_T3, REG_H1, REG_H2, REG_H345, REG_H6, REG_H7
  } thc_cal_reg_e;

  // Humidity ceiling in thousandths of a percent.
  localparam logic [HUM_OUT_W-1:0] HUM_MAX = 17'd100000;

  // Division by 100 through a reciprocal: exact for magnitudes below 2^DIV_W
  // when the shift is DIV_W + 7 and the multiplier is rounded upwards.
  localparam int DIV_W       = 28;
  localparam int DIV_SHIFT   = DIV_W + 7;
  localparam int DIV_RECIP_W = 29;
  localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = 29'd343597384;

  // Temperature calibration as the temperature pipeline sees it.
  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [7:0]  t3;
  } thc_temp_cal_t;

  // Humidity calibration as the humidity pipeline sees it.
  typedef struct packed {
    logic [11:0] h1;
    logic [11:0] h2;
    logic [7:0]  h3;
    logic [7:0]  h4;
    logic [7:0]  h5;
    logic [7:0]  h6;
    logic [7:0]  h7;
  } thc_hum_cal_t;

  // Hand-over from the temperature pipeline to the humidity pipeline.
  typedef struct packed {
    logic                  valid;
    logic [TEMP_W-1:0]     temp;
    logic [TEMP_OUT_W-1:0] temp_sat;
    logic [HUM_RAW_W-1:0]  hum_raw;
  } thc_temp_res_t;

  // Signed division by 100 that truncates towards zero.
  function automatic logic signed [DIV_W-1:0] div100(input logic signed [DIV_W-1:0] x);
    logic [DIV_W-1:0]             mag;
    logic [DIV_W+DIV_RECIP_W-1:0] prod;
    logic [DIV_W-1:0]             quo;
    mag  = x[DIV_W-1] ? DIV_W'(-x) : DIV_W'(x);
    prod = (DIV_W+DIV_RECIP_W)'(mag) * (DIV_W+DIV_RECIP_W)'(DIV_RECIP);
    quo  = DIV_W'(prod >> DIV_SHIFT);
    return x[DIV_W-1] ? -$signed(quo) : $signed(quo);
  endfunction

endpackage

`default_nettype wire

// ===== design/thc_temp_pipe.sv =====
// Four-stage pipeline that turns the raw temperature into hundredths of a degree.
`timescale 1ns / 1ps
`default_nettype none

module thc_temp_pipe (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            adv_i,
  input  wire logic                            in_valid_i,
  input  wire logic [thc_pkg::TEMP_RAW_W-1:0]  temp_raw_i,
  input  wire logic [thc_pkg::HUM_RAW_W-1:0]   hum_raw_i,
  input  wire thc_pkg::thc_temp_cal_t          cal_i,
  output thc_pkg::thc_temp_res_t               res_o
);

  logic signed [15:0] t2;
  logic signed [7:0]  t3;
  assign t2 = $signed(cal_i.t2);
  assign t3 = $signed(cal_i.t3);

  // Stage 1: offset of the raw reading against t1.
  logic signed [17:0] d_d, d_q;
  logic               v1_q;
  logic [15:0]        hraw1_q;
  assign d_d = $signed({1'b0, temp_raw_i[19:3]}) - $signed({1'b0, cal_i.t1, 1'b0});

  // Stage 2: linear product and square of the halved offset.
  logic signed [16:0] half;
  logic signed [33:0] lin_prod_d, lin_prod_q;
  logic signed [33:0] hsq_d, hsq_q;
  logic               v2_q;
  logic [15:0]        hraw2_q;
  assign half       = 17'(d_q >>> 1);
  assign lin_prod_d = 34'(d_q) * 34'(t2);
  assign hsq_d      = 34'(half) * 34'(half);

  // Stage 3: scale the linear term and form the quadratic product with t3.
  logic signed [21:0] quad_base;
  logic signed [11:0] t3x16;
  logic signed [22:0] lin_d, lin_q;
  logic signed [31:0] qprod_d, qprod_q;
  logic               v3_q;
  logic [15:0]        hraw3_q;
  assign quad_base = 22'(hsq_q >>> 12);
  assign t3x16     = {t3, 4'b0000};
  assign lin_d     = 23'(lin_prod_q >>> 11);
  assign qprod_d   = 32'(quad_base) * 32'(t3x16);

  // Stage 4: fine value, temperature in hundredths and its 16-bit saturation.
  logic signed [23:0] fine;
  logic signed [26:0] fine5;
  logic signed [16:0] temp_d;
  logic [15:0]        tsat_d;
  assign fine   = 24'(lin_q) + 24'(qprod_q >>> 14);
  assign fine5  = (27'(fine) <<< 2) + 27'(fine) + 27'sd128;
  assign temp_d = 17'(fine5 >>> 8);

  always_comb begin
    if (temp_d > 17'sd32767) begin
      tsat_d = 16'h7fff;
    end else if (temp_d < -17'sd32768) begin
      tsat_d = 16'h8000;
    end else begin
      tsat_d = temp_d[15:0];
    end
  end

  // Valid bits travel with the data and freeze while the pipeline stalls.
  logic v4_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Payload registers.
  logic [16:0] temp_q;
  logic [15:0] tsat_q;
  logic [15:0] hraw4_q;
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      d_q        <= d_d;
      hraw1_q    <= hum_raw_i;
      lin_prod_q <= lin_prod_d;
      hsq_q      <= hsq_d;
      hraw2_q    <= hraw1_q;
      lin_q      <= lin_d;
      qprod_q    <= qprod_d;
      hraw3_q    <= hraw2_q;
      temp_q     <= temp_d;
      tsat_q     <= tsat_d;
      hraw4_q    <= hraw3_q;
    end
  end

  assign res_o.valid    = v4_q;
  assign res_o.temp     = temp_q;
  assign res_o.temp_sat = tsat_q;
  assign res_o.hum_raw  = hraw4_q;

endmodule

`default_nettype wire

// ===== design/thc_hum_pipe.sv =====
// Twelve-stage pipeline that forms the clamped humidity from the temperature.
`timescale 1ns / 1ps
`default_nettype none

module thc_hum_pipe (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            adv_i,
  input  wire thc_pkg::thc_temp_res_t          in_i,
  input  wire thc_pkg::thc_hum_cal_t           cal_i,
  output logic                                 out_valid_o,
  output logic [thc_pkg::TEMP_OUT_W-1:0]       temp_o,
  output logic [thc_pkg::HUM_OUT_W-1:0]        hum_o
);

  logic signed [16:0] temp_in;
  assign temp_in = $signed(in_i.temp);

  // Stage 1: temperature times each of h3, h4, h5 and h7.
  logic signed [23:0] p3_d, p4_d, p5_d, p7_d;
  logic signed [23:0] p3_q, p4_q, p5_q, p7_q;
  logic signed [16:0] temp1_q;
  logic [15:0]        hraw1_q;
  assign p3_d = 24'(temp_in) * 24'($signed(cal_i.h3));
  assign p4_d = 24'(temp_in) * 24'($signed(cal_i.h4));
  assign p5_d = 24'(temp_in) * 24'($signed(cal_i.h5));
  assign p7_d = 24'(temp_in) * 24'($signed(cal_i.h7));

  // Stage 2: the four products divided by 100.
  logic signed [16:0] q3_d, q4_d, q5_d, q7_d;
  logic signed [16:0] q3_q, q4_q, q5_q, q7_q;
  logic signed [16:0] temp2_q;
  logic [15:0]        hraw2_q;
  assign q3_d = 17'(thc_pkg::div100(thc_pkg::DIV_W'(p3_q)));
  assign q4_d = 17'(thc_pkg::div100(thc_pkg::DIV_W'(p4_q)));
  assign q5_d = 17'(thc_pkg::div100(thc_pkg::DIV_W'(p5_q)));
  assign q7_d = 17'(thc_pkg::div100(thc_pkg::DIV_W'(p7_q)));

  // Stage 3: second-order temperature product, humidity offset and curve term.
  logic signed [33:0] tq5_d, tq5_q;
  logic signed [18:0] off_d, off_q3;
  logic signed [18:0] curve_sum;
  logic signed [13:0] curve_d, curve_q3;
  logic signed [16:0] q4_q3;
  assign tq5_d     = 34'(temp2_q) * 34'(q5_q);
  assign off_d     = 19'($signed({1'b0, hraw2_q})) - 19'($signed({1'b0, cal_i.h1, 4'b0000}))
                     - 19'(q3_q >>> 1);
  assign curve_sum = 19'($signed({1'b0, cal_i.h6, 7'b0000000})) + 19'(q7_q);
  assign curve_d   = 14'(curve_sum >>> 4);

  // Stage 4: the second-order product scaled and divided by 100.
  logic signed [19:0] r_d, r_q;
  logic signed [18:0] off_q4;
  logic signed [13:0] curve_q4;
  logic signed [16:0] q4_q4;
  assign r_d = 20'(thc_pkg::div100(thc_pkg::DIV_W'(tq5_q >>> 6)));

  // Stage 5: gain sum times h2.
  logic signed [20:0] inner;
  logic signed [32:0] gprod_d, gprod_q;
  logic signed [18:0] off_q5;
  logic signed [13:0] curve_q5;
  assign inner   = 21'(q4_q4) + 21'(r_q) + 21'sd16384;
  assign gprod_d = 33'(inner) * 33'($signed({1'b0, cal_i.h2}));

  // Stage 6: offset times gain.
  logic signed [22:0] gain;
  logic signed [41:0] prod_d, prod_q6;
  logic signed [13:0] curve_q6;
  assign gain   = 23'(gprod_q >>> 10);
  assign prod_d = 42'(off_q5) * 42'(gain);

  // Stage 7: partial products of the square of the scaled product.
  logic signed [25:0] sq_base;
  logic [25:0]        sq_mag;
  logic [25:0]        pp_hh_d, pp_hl_d, pp_ll_d;
  logic [25:0]        pp_hh_q, pp_hl_q, pp_ll_q;
  logic signed [41:0] prod_q7;
  logic signed [13:0] curve_q7;
  assign sq_base = 26'(prod_q6 >>> 14);
  assign sq_mag  = sq_base[25] ? 26'(-sq_base) : 26'(sq_base);
  assign pp_hh_d = 26'(sq_mag[25:13]) * 26'(sq_mag[25:13]);
  assign pp_hl_d = 26'(sq_mag[25:13]) * 26'(sq_mag[12:0]);
  assign pp_ll_d = 26'(sq_mag[12:0]) * 26'(sq_mag[12:0]);

  // Stage 8: sum of the partial products, scaled down.
  logic [51:0]        sq_full;
  logic [41:0]        sq_d, sq_q;
  logic signed [41:0] prod_q8;
  logic signed [13:0] curve_q8;
  assign sq_full = (52'(pp_hh_q) << 26) + (52'(pp_hl_q) << 14) + 52'(pp_ll_q);
  assign sq_d    = 42'(sq_full >> 10);

  // Stage 9: curve term times the square, as two halves.
  logic signed [35:0] chi_d, clo_d, chi_q, clo_q;
  logic signed [41:0] prod_q9;
  assign chi_d = 36'(curve_q8) * 36'($signed({1'b0, sq_q[41:21]}));
  assign clo_d = 36'(curve_q8) * 36'($signed({1'b0, sq_q[20:0]}));

  // Stage 10: recombine the halves into the correction.
  logic signed [56:0] cmul;
  logic signed [55:0] corr_d, corr_q;
  logic signed [41:0] prod_q10;
  assign cmul   = (57'(chi_q) <<< 21) + 57'(clo_q);
  assign corr_d = 56'(cmul >>> 1);

  // Stage 11: product plus correction, scaled down.
  logic signed [56:0] hsum;
  logic signed [46:0] v_d, v_q;
  assign hsum = 57'(prod_q10) + 57'(corr_q);
  assign v_d  = 47'(hsum >>> 10);

  // Stage 12: times 1000 by shifts, scale and clamp into the output register.
  logic signed [57:0] w;
  logic signed [57:0] hum_full;
  logic [16:0]        hum_d, hum_q;
  assign w        = (58'(v_q) <<< 10) - (58'(v_q) <<< 4) - (58'(v_q) <<< 3);
  assign hum_full = w >>> 12;

  always_comb begin
    if (hum_full > 58'sd100000) begin
      hum_d = thc_pkg::HUM_MAX;
    end else if (hum_full < 58'sd0) begin
      hum_d = '0;
    end else begin
      hum_d = hum_full[16:0];
    end
  end

  // Valid bits, one per stage; the whole row holds while the output stalls.
  logic [11:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[10:0], in_i.valid};
    end
  end

  // Saturated temperature rides alongside the humidity work.
  logic [15:0] tsat_q [12];
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tsat_q[0] <= in_i.temp_sat;
      for (int i = 1; i < 12; i++) begin
        tsat_q[i] <= tsat_q[i-1];
      end
    end
  end

  // Payload registers of the humidity stages.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p3_q     <= p3_d;
      p4_q     <= p4_d;
      p5_q     <= p5_d;
      p7_q     <= p7_d;
      temp1_q  <= temp_in;
      hraw1_q  <= in_i.hum_raw;
      q3_q     <= q3_d;
      q4_q     <= q4_d;
      q5_q     <= q5_d;
      q7_q     <= q7_d;
      temp2_q  <= temp1_q;
      hraw2_q  <= hraw1_q;
      tq5_q    <= tq5_d;
      off_q3   <= off_d;
      curve_q3 <= curve_d;
      q4_q3    <= q4_q;
      r_q      <= r_d;
      off_q4   <= off_q3;
      curve_q4 <= curve_q3;
      q4_q4    <= q4_q3;
      gprod_q  <= gprod_d;
      off_q5   <= off_q4;
      curve_q5 <= curve_q4;
      prod_q6  <= prod_d;
      curve_q6 <= curve_q5;
      pp_hh_q  <= pp_hh_d;
      pp_hl_q  <= pp_hl_d;
      pp_ll_q  <= pp_ll_d;
      prod_q7  <= prod_q6;
      curve_q7 <= curve_q6;
      sq_q     <= sq_d;
      prod_q8  <= prod_q7;
      curve_q8 <= curve_q7;
      chi_q    <= chi_d;
      clo_q    <= clo_d;
      prod_q9  <= prod_q8;
      corr_q   <= corr_d;
      prod_q10 <= prod_q9;
      v_q      <= v_d;
      hum_q    <= hum_d;
    end
  end

  assign out_valid_o = vld_q[11];
  assign temp_o      = tsat_q[11];
  assign hum_o       = hum_q;

endmodule

`default_nettype wire

// ===== design/temp_humidity_compensation.sv =====
// Top level of the temperature and humidity compensation block.
// The block takes one raw temperature and humidity pair per transfer and
// returns one compensated pair per transfer: temperature in hundredths of a
// degree, saturated to 16 bits signed, and relative humidity in thousandths
// of a percent, clamped to 0..100000. It sustains one transfer per clock
// cycle while the output is not held off, through four stages for
// the temperature and twelve for the humidity, each stage holding roughly one
// multiplier's depth of logic. When the output transfer is held off the whole
// pipeline freezes, so input ready follows output ready in the same cycle.
// Calibration registers are written through the configuration channel,
// which is always ready, and must only change while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none
`include "temp_humidity_compensation_assert.svh"

module temp_humidity_compensation (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [thc_pkg::TEMP_RAW_W-1:0]  temp_raw_i,
  input  wire logic [thc_pkg::HUM_RAW_W-1:0]   hum_raw_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic signed [thc_pkg::TEMP_OUT_W-1:0] temp_centideg_o,
  output logic [thc_pkg::HUM_OUT_W-1:0]        hum_millipct_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [thc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [thc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  // Calibration registers, cleared by reset.
  logic [15:0] cal_t1_q, cal_t2_q;
  logic [7:0]  cal_t3_q;
  logic [11:0] cal_h1_q, cal_h2_q;
  logic [23:0] cal_h345_q;
  logic [7:0]  cal_h6_q, cal_h7_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_t1_q   <= '0;
      cal_t2_q   <= '0;
      cal_t3_q   <= '0;
      cal_h1_q   <= '0;
      cal_h2_q   <= '0;
      cal_h345_q <= '0;
      cal_h6_q   <= '0;
      cal_h7_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        thc_pkg::REG_T1:   cal_t1_q   <= cfg_data_i[15:0];
        thc_pkg::REG_T2:   cal_t2_q   <= cfg_data_i[15:0];
        thc_pkg::REG_T3:   cal_t3_q   <= cfg_data_i[7:0];
        thc_pkg::REG_H1:   cal_h1_q   <= cfg_data_i[11:0];
        thc_pkg::REG_H2:   cal_h2_q   <= cfg_data_i[11:0];
        thc_pkg::REG_H345: cal_h345_q <= cfg_data_i;
        thc_pkg::REG_H6:   cal_h6_q   <= cfg_data_i[7:0];
        thc_pkg::REG_H7:   cal_h7_q   <= cfg_data_i[7:0];
        default:           cal_t1_q   <= cal_t1_q;
      endcase
    end
  end

  thc_pkg::thc_temp_cal_t temp_cal;
  thc_pkg::thc_hum_cal_t  hum_cal;

  assign temp_cal.t1 = cal_t1_q;
  assign temp_cal.t2 = cal_t2_q;
  assign temp_cal.t3 = cal_t3_q;
  assign hum_cal.h1  = cal_h1_q;
  assign hum_cal.h2  = cal_h2_q;
  assign hum_cal.h3  = cal_h345_q[7:0];
  assign hum_cal.h4  = cal_h345_q[15:8];
  assign hum_cal.h5  = cal_h345_q[23:16];
  assign hum_cal.h6  = cal_h6_q;
  assign hum_cal.h7  = cal_h7_q;

  // The pipeline moves whenever the output register is empty or being taken.
  logic adv;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  thc_pkg::thc_temp_res_t temp_res;
  logic [thc_pkg::TEMP_OUT_W-1:0] temp_out;

  thc_temp_pipe u_temp_pipe (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .in_valid_i (in_valid_i),
    .temp_raw_i (temp_raw_i),
    .hum_raw_i  (hum_raw_i),
    .cal_i      (temp_cal),
    .res_o      (temp_res)
  );

  thc_hum_pipe u_hum_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .in_i        (temp_res),
    .cal_i       (hum_cal),
    .out_valid_o (out_valid_o),
    .temp_o      (temp_out),
    .hum_o       (hum_millipct_o)
  );

  assign temp_centideg_o = $signed(temp_out);

  // Checks on the block's own logic.
  `THC_ASSERT_NOW(a_hum_clamped, out_valid_o, hum_millipct_o <= thc_pkg::HUM_MAX, "humidity above ceiling")
  `THC_ASSERT_NOW(a_stall_blocks_input, out_valid_o && !out_ready_i, !in_ready_o, "input taken during stall")
  `THC_ASSERT_NEXT(a_h6_write, cfg_valid_i && cfg_ready_o && (cfg_index_i == thc_pkg::REG_H6),
                   cal_h6_q == $past(cfg_data_i[7:0]), "h6 write lost")

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench of the temperature and humidity compensation block.
`timescale 1ns / 1ps

module tb_top;

  typedef struct {
    thc_pkg::thc_cal_reg_e          idx;
    logic [thc_pkg::CFG_DATA_W-1:0] data;
  } cal_write_t;

  typedef struct packed {
    logic [thc_pkg::TEMP_RAW_W-1:0] temp_raw;
    logic [thc_pkg::HUM_RAW_W-1:0]  hum_raw;
  } sample_t;

  typedef struct packed {
    logic signed [thc_pkg::TEMP_OUT_W-1:0] temp;
    logic [thc_pkg::HUM_OUT_W-1:0]         hum;
  } reading_t;

  // Clock, reset and block ports; the driven ones start at known values from time zero.
  logic                                  clk_i           = 1'b0;
  logic                                  rst_ni          = 1'b0;
  logic                                  in_valid_i      = 1'b0;
  logic                                  in_ready_o;
  logic [thc_pkg::TEMP_RAW_W-1:0]        temp_raw_i      = '0;
  logic [thc_pkg::HUM_RAW_W-1:0]         hum_raw_i       = '0;
  logic                                  out_valid_o;
  logic                                  out_ready_i     = 1'b0;
  logic signed [thc_pkg::TEMP_OUT_W-1:0] temp_centideg_o;
  logic [thc_pkg::HUM_OUT_W-1:0]         hum_millipct_o;
  logic                                  cfg_valid_i     = 1'b0;
  logic                                  cfg_ready_o;
  logic [thc_pkg::CFG_IDX_W-1:0]         cfg_index_i     = '0;
  logic [thc_pkg::CFG_DATA_W-1:0]        cfg_data_i      = '0;

  // Testbench copy of the calibration registers, updated on each write transfer.
  logic [thc_pkg::CFG_DATA_W-1:0] cal_regs [8] = '{default: '0};

  sample_t     samples [$];
  cal_write_t  cal_writes [$];
  reading_t    pending_readings [$];
  reading_t    oldest_reading;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int          err_count      = 0;

  temp_humidity_compensation dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .temp_raw_i      (temp_raw_i),
    .hum_raw_i       (hum_raw_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .temp_centideg_o (temp_centideg_o),
    .hum_millipct_o  (hum_millipct_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // Integer compensation at full 64-bit precision. Arithmetic right shifts
  // round towards minus infinity and divisions by 100 truncate towards zero.
  function automatic reading_t compensate(input logic [thc_pkg::TEMP_RAW_W-1:0] traw_v,
                                          input logic [thc_pkg::HUM_RAW_W-1:0] hraw_v);
    longint   traw, hraw, t1, t2, t3, h1, h2, h3, h4, h5, h6, h7;
    longint   d, lin, half, quad, fine, temp, tsat;
    longint   off, gain, prod, curve, sq, corr, hum;
    reading_t r;
    traw = longint'(traw_v);
    hraw = longint'(hraw_v);
    t1   = longint'(cal_regs[thc_pkg::REG_T1][15:0]);
    t2   = longint'($signed(cal_regs[thc_pkg::REG_T2][15:0]));
    t3   = longint'($signed(cal_regs[thc_pkg::REG_T3][7:0]));
    h1   = longint'(cal_regs[thc_pkg::REG_H1][11:0]);
    h2   = longint'(cal_regs[thc_pkg::REG_H2][11:0]);
    h3   = longint'($signed(cal_regs[thc_pkg::REG_H345][7:0]));
    h4   = longint'($signed(cal_regs[thc_pkg::REG_H345][15:8]));
    h5   = longint'($signed(cal_regs[thc_pkg::REG_H345][23:16]));
    h6   = longint'(cal_regs[thc_pkg::REG_H6][7:0]);
    h7   = longint'($signed(cal_regs[thc_pkg::REG_H7][7:0]));

    // Temperature: linear and quadratic terms of the offset raw reading.
    d    = (traw >>> 3) - t1 * 2;
    lin  = (d * t2) >>> 11;
    half = d >>> 1;
    quad = (half * half) >>> 12;
    quad = (quad * (t3 * 16)) >>> 14;
    fine = lin + quad;
    temp = (fine * 5 + 128) >>> 8;
    tsat = temp;
    if (tsat > 32767) tsat = 32767;
    if (tsat < -32768) tsat = -32768;

    // Humidity works from the unsaturated temperature.
    off   = hraw - h1 * 16 - (((temp * h3) / 100) >>> 1);
    gain  = (h2 * ((temp * h4) / 100
                   + ((temp * ((temp * h5) / 100)) >>> 6) / 100
                   + 16384)) >>> 10;
    prod  = off * gain;
    curve = (h6 * 128 + (temp * h7) / 100) >>> 4;
    sq    = ((prod >>> 14) * (prod >>> 14)) >>> 10;
    corr  = (curve * sq) >>> 1;
    hum   = (((prod + corr) >>> 10) * 1000) >>> 12;
    if (hum > 100000) hum = 100000;
    if (hum < 0) hum = 0;

    r.temp = thc_pkg::TEMP_OUT_W'(tsat);
    r.hum  = thc_pkg::HUM_OUT_W'(hum);
    return r;
  endfunction

  // Picks a calibration value: all zeros, all ones or random bits.
  function automatic logic [thc_pkg::CFG_DATA_W-1:0] rand_cal();
    int unsigned pick;
    pick = $urandom_range(3);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return thc_pkg::CFG_DATA_W'($urandom());
  endfunction

  // Calibration word from an integer, keeping its low bits.
  function automatic logic [thc_pkg::CFG_DATA_W-1:0] cal_word(input int v);
    return thc_pkg::CFG_DATA_W'(v);
  endfunction

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Sample driver: presents the oldest pending sample and records its
  // expected reading when the transfer completes.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      logic next_valid;
      next_valid = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        pending_readings.push_back(compensate(temp_raw_i, hum_raw_i));
        void'(samples.pop_front());
        next_valid = 1'b0;
      end
      if (!next_valid && samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        temp_raw_i <= samples[0].temp_raw;
        hum_raw_i  <= samples[0].hum_raw;
        next_valid = 1'b1;
      end
      in_valid_i <= next_valid;
    end
  end

  // Configuration driver: the register copy changes on the write transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_valid_i <= 1'b0;
    end else begin
      logic next_cfg;
      next_cfg = cfg_valid_i;
      if (cfg_valid_i && cfg_ready_o) begin
        cal_regs[cfg_index_i] = cfg_data_i;
        void'(cal_writes.pop_front());
        next_cfg = 1'b0;
      end
      if (!next_cfg && cal_writes.size() != 0) begin
        cfg_index_i <= cal_writes[0].idx;
        cfg_data_i  <= cal_writes[0].data;
        next_cfg = 1'b1;
      end
      cfg_valid_i <= next_cfg;
    end
  end

  // Result monitor: each output transfer is checked against the oldest
  // expected reading.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (pending_readings.size() == 0) begin
          err_count++;
          $display("%0t: unexpected reading, expected none, actual temp %0d hum %0d",
                   $time, temp_centideg_o, hum_millipct_o);
        end else begin
          oldest_reading = pending_readings.pop_front();
          if (temp_centideg_o !== oldest_reading.temp) begin
            err_count++;
            $display("%0t: temp_centideg mismatch, expected %0d, actual %0d",
                     $time, oldest_reading.temp, temp_centideg_o);
          end
          if (hum_millipct_o !== oldest_reading.hum) begin
            err_count++;
            $display("%0t: hum_millipct mismatch, expected %0d, actual %0d",
                     $time, oldest_reading.hum, hum_millipct_o);
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Waits until every sample has been sent and every reading has arrived,
  // then lets the pipeline settle.
  task automatic wait_idle();
    while (samples.size() != 0 || pending_readings.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Writes all eight calibration registers while the block is idle.
  task automatic program_cal(input logic [thc_pkg::CFG_DATA_W-1:0] t1, t2, t3, h1, h2,
                             input logic [thc_pkg::CFG_DATA_W-1:0] h345, h6, h7);
    logic [thc_pkg::CFG_DATA_W-1:0] vals [8];
    cal_write_t                     w;
    vals = '{t1, t2, t3, h1, h2, h345, h6, h7};
    wait_idle();
    for (int i = 0; i < 8; i++) begin
      w.idx  = thc_pkg::thc_cal_reg_e'(i);
      w.data = vals[i];
      cal_writes.push_back(w);
    end
    while (cal_writes.size() != 0) @(posedge clk_i);
  endtask

  task automatic add_sample(input int traw, input int hraw);
    samples.push_back('{thc_pkg::TEMP_RAW_W'(traw), thc_pkg::HUM_RAW_W'(hraw)});
  endtask

  // Stimulus sequence.
  initial begin
    int traw, hraw;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Registers at their reset values.
    add_sample(0, 0);
    add_sample(1048575, 65535);

    // Typical calibration: room temperature, negative temperatures and
    // both humidity clamps. The h7 byte holds minus 100.
    program_cal(24'd26000, 24'd26000, 24'd3, 24'd800, 24'd1000, 24'h142D00, 24'd120,
                24'h00009C);
    add_sample(500000, 20000);
    add_sample(500000, 40000);
    add_sample(416000, 30000);
    add_sample(300000, 25000);
    add_sample(0, 65535);
    add_sample(1048575, 0);
    add_sample(520000, 65535);
    add_sample(480000, 0);

    // Largest positive coefficients but a zero t1, with stray upper bits in the writes.
    // Pushes the temperature into positive saturation.
    program_cal(24'hFF0000, 24'hAB7FFF, 24'h00FF7F, 24'hFFFFFF, 24'h000FFF,
                24'h7F7F7F, 24'h0000FF, 24'h00007F);
    add_sample(1048575, 0);
    add_sample(1048575, 65535);
    add_sample(0, 65535);
    add_sample(524288, 32768);

    // Most negative signed coefficients and largest offset: low readings saturate positive.
    program_cal(24'h00FFFF, 24'h008000, 24'h000080, 24'h000000, 24'h000FFF,
                24'h808080, 24'h000000, 24'h000080);
    add_sample(0, 0);
    add_sample(0, 65535);
    add_sample(1048575, 65535);
    add_sample(8, 1);

    // Random part: four idling modes, each over four calibration settings.
    for (int s = 0; s < 16; s++) begin
      wait_idle();
      case (s / 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      if (s % 2 == 0) begin
        // Plausible calibration, so that humidity lands inside its range.
        program_cal(cal_word(25000 + int'($urandom_range(2000))),
                    cal_word(25000 + int'($urandom_range(2000))),
                    cal_word(int'($urandom_range(6)) - 3),
                    cal_word(600 + int'($urandom_range(400))),
                    cal_word(800 + int'($urandom_range(400))),
                    {8'($urandom_range(40)), 8'(30 + $urandom_range(30)),
                     8'($urandom_range(8) - 4)},
                    cal_word(100 + int'($urandom_range(40))),
                    cal_word(-90 - int'($urandom_range(20))));
      end else begin
        program_cal(rand_cal(), rand_cal(), rand_cal(), rand_cal(),
                    rand_cal(), rand_cal(), rand_cal(), rand_cal());
      end
      for (int n = 0; n < 118; n++) begin
        // Half the samples sit near the temperature offset point.
        if ($urandom_range(1) == 0) begin
          traw = $urandom_range(20'hFFFFF);
        end else begin
          traw = int'(cal_regs[thc_pkg::REG_T1][15:0]) * 16
                 + int'($urandom_range(200000)) - 100000;
          if (traw < 0) traw = 0;
          if (traw > 1048575) traw = 1048575;
        end
        if ($urandom_range(1) == 0) begin
          hraw = $urandom_range(16'hFFFF);
        end else begin
          hraw = int'(cal_regs[thc_pkg::REG_H1][11:0]) * 16
                 + int'($urandom_range(60000)) - 20000;
          if (hraw < 0) hraw = 0;
          if (hraw > 65535) hraw = 65535;
        end
        add_sample(traw, hraw);
      end
    end

    wait_idle();
    if (err_count == 0) begin
      $display("** temp_humidity_compensation: PASSED **");
    end else begin
      $display("** temp_humidity_compensation: FAILED **");
    end
    $finish;
  end

  // Watchdog on the whole run.
  initial begin
    #5000000;
    $display("** temp_humidity_compensation: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/thc_pkg.sv
design/thc_temp_pipe.sv
design/thc_hum_pipe.sv
design/temp_humidity_compensation.sv
sim/tb_top.sv
